// ===== hw/rtl/hvn_pkg.sv =====
// Package for the heightmap vertex normal unit: shared types and constants.
// No dependencies.
package hvn_pkg;
  // height store geometry, address is row * MAX_COLS + col
  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned MAX_ROWS = 256;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT_DIV  = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_WAIT, ST_CELL_SQ, ST_CELL_SQRT, ST_CELL_DIV,
    ST_SUM_SQ, ST_SUM_SQRT, ST_SUM_DIV, ST_OUT
  } state_t;

  // root/divide unit request and response
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [79:0] a;
    logic [47:0] d;
  } mu_req_t;

  typedef struct packed {
    logic        done;
    logic [79:0] q;
  } mu_rsp_t;
endpackage

// ===== hw/rtl/hvn_if.sv =====
// Valid/ready channel interfaces for the heightmap vertex normal unit.
// Depends on nothing.
interface hvn_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] height;
  modport source (output valid, kind, row, col, height, input ready);
  modport sink   (input valid, kind, row, col, height, output ready);
endinterface

interface hvn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface hvn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hvn_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module hvn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/hvn_mathu.sv =====
// Shared iterative unit: 80-bit integer square root or 80/48 division,
// one result bit per cycle. Depends on hvn_pkg.
module hvn_mathu (
  input  logic            clk,
  input  logic            rst_n,
  input  hvn_pkg::mu_req_t req,
  output hvn_pkg::mu_rsp_t rsp
);
  logic        busy_r, busy_nxt, div_r, div_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [79:0] a_r, a_nxt, q_r, q_nxt;
  logic [81:0] rem_r, rem_nxt;
  logic [47:0] d_r, d_nxt;
  logic [81:0] trial, diff;

  always_comb begin
    busy_nxt = busy_r; div_nxt = div_r; cnt_nxt = cnt_r;
    a_nxt = a_r; q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r;
    trial = '0; diff = '0;
    rsp.done = 1'b0;
    rsp.q = q_r;
    if (req.start) begin
      busy_nxt = 1'b1; div_nxt = req.is_div; a_nxt = req.a; d_nxt = req.d;
      q_nxt = '0; rem_nxt = '0;
      cnt_nxt = req.is_div ? 7'd80 : 7'd40;
    end else if (busy_r) begin
      if (div_r) begin
        // restoring division, one quotient bit
        trial = {rem_r[80:0], a_r[79]};
        diff = trial - {34'd0, d_r};
        a_nxt = {a_r[78:0], 1'b0};
        if (!diff[81]) begin
          rem_nxt = diff; q_nxt = {q_r[78:0], 1'b1};
        end else begin
          rem_nxt = trial; q_nxt = {q_r[78:0], 1'b0};
        end
      end else begin
        // digit-by-digit root, two radicand bits a step
        trial = {rem_r[79:0], a_r[79:78]};
        diff = trial - {q_r[79:0], 2'b01};
        a_nxt = {a_r[77:0], 2'b00};
        if (!diff[81]) begin
          rem_nxt = diff; q_nxt = {q_r[78:0], 1'b1};
        end else begin
          rem_nxt = trial; q_nxt = {q_r[78:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
    // result bit of the final step is combined in the completing cycle
    if (busy_r && cnt_r == 7'd1) begin
      rsp.done = 1'b1;
      rsp.q = q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; div_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; div_r <= div_nxt;
    end
    a_r <= a_nxt; q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end
endmodule

// ===== hw/rtl/hvn_ctrl.sv =====
// Query sequencer: fetches samples, forms cell normals, sums and
// renormalizes. Depends on hvn_pkg and hvn_mathu.
module hvn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [7:0]        row,
  input  logic [7:0]        col,
  input  logic [8:0]        w,
  input  logic [8:0]        h,
  input  logic [15:0]       dv,
  input  logic              out_free,
  output logic [15:0]       rd_addr,
  input  logic [7:0]        rd_data,
  output logic              busy,
  output logic              done,
  output logic signed [15:0] nx,
  output logic signed [15:0] ny,
  output logic signed [15:0] nz
);
  hvn_pkg::state_t st_r, st_nxt;
  hvn_pkg::mu_req_t req;
  hvn_pkg::mu_rsp_t rsp;
  logic [1:0]  cell_r, cell_nxt;
  logic [1:0]  smp_r, smp_nxt;
  logic [1:0]  cmp_r, cmp_nxt;
  logic [7:0]  row_r, row_nxt, col_r, col_nxt;
  logic [7:0]  h00_r, h10_r, h11_r;
  logic [7:0]  h00_nxt, h10_nxt, h11_nxt;
  logic signed [16:0] v_r [3];
  logic signed [23:0] acc_r [3];
  logic signed [23:0] acc_nxt [3];
  logic [47:0] sq_r, sq_nxt;
  logic [47:0] s_r, s_nxt;
  logic signed [15:0] o_r [3];
  logic signed [15:0] o_nxt [3];
  logic [7:0]  rr, cc;
  logic        cell_ok;
  logic signed [16:0] vk;
  logic signed [23:0] ak;
  logic [16:0] vmag;
  logic [23:0] amag;
  logic [79:0] qv;
  logic [16:0] qsat;

  hvn_mathu u_mu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // cell origin and presence for cell index 0..3 (UL, UR, LL, LR)
  always_comb begin
    rr = cell_r[1] ? row_r : row_r - 8'd1;
    cc = cell_r[0] ? col_r : col_r - 8'd1;
    cell_ok = (cell_r[1] ? ({1'b0, row_r} + 9'd1 < h) : (row_r != 8'd0)) &&
              (cell_r[0] ? ({1'b0, col_r} + 9'd1 < w) : (col_r != 8'd0));
  end

  always_comb begin
    rd_addr = {rr, cc};
    case (smp_r)
      2'd1:    rd_addr = {rr + 8'd1, cc};
      2'd2:    rd_addr = {rr + 8'd1, cc + 8'd1};
      default: rd_addr = {rr, cc};
    endcase
  end

  always_comb begin
    vk = v_r[cmp_r];
    ak = acc_r[cmp_r];
    vmag = vk[16] ? -vk : vk;
    amag = ak[23] ? -ak : ak;
  end

  always_comb begin
    st_nxt = st_r; cell_nxt = cell_r; smp_nxt = smp_r; cmp_nxt = cmp_r;
    row_nxt = row_r; col_nxt = col_r;
    h00_nxt = h00_r; h10_nxt = h10_r; h11_nxt = h11_r;
    acc_nxt = acc_r; sq_nxt = sq_r; s_nxt = s_r; o_nxt = o_r;
    req = '0; qv = rsp.q; qsat = '0;
    busy = (st_r != hvn_pkg::ST_IDLE);
    done = 1'b0;
    case (st_r)
      hvn_pkg::ST_IDLE: begin
        if (start) begin
          st_nxt = hvn_pkg::ST_FETCH; cell_nxt = 2'd0; smp_nxt = 2'd0;
          row_nxt = row; col_nxt = col;
          for (int k = 0; k < 3; k++) acc_nxt[k] = '0;
        end
      end
      hvn_pkg::ST_FETCH: begin
        // skip absent cells, else issue the first read
        if (!cell_ok) begin
          if (cell_r == 2'd3) begin
            st_nxt = hvn_pkg::ST_SUM_SQ; cmp_nxt = 2'd0; sq_nxt = '0;
          end
          cell_nxt = cell_r + 2'd1;
        end else begin
          smp_nxt = 2'd1; st_nxt = hvn_pkg::ST_WAIT;
        end
      end
      hvn_pkg::ST_WAIT: begin
        // data for the sample issued last cycle
        case (smp_r)
          2'd1: h00_nxt = rd_data;
          2'd2: h10_nxt = rd_data;
          default: h11_nxt = rd_data;
        endcase
        if (smp_r == 2'd3) begin
          st_nxt = hvn_pkg::ST_CELL_SQ; cmp_nxt = 2'd0; sq_nxt = '0;
        end else smp_nxt = smp_r + 2'd1;
      end
      hvn_pkg::ST_CELL_SQ: begin
        sq_nxt = sq_r + 48'(vmag) * 48'(vmag);
        if (cmp_r == 2'd2) st_nxt = hvn_pkg::ST_CELL_SQRT;
        else cmp_nxt = cmp_r + 2'd1;
      end
      hvn_pkg::ST_CELL_SQRT: begin
        req.start = (cmp_r == 2'd2); req.is_div = 1'b0; req.a = {sq_r[47:0], 20'd0, 12'd0};
        cmp_nxt = 2'd3;
        if (rsp.done) begin
          // root of sq*2^32 is the wanted root times 2^16; drop six low bits
          s_nxt = 48'(qv[79:6]); cmp_nxt = 2'd0; st_nxt = hvn_pkg::ST_CELL_DIV;
          req.start = 1'b0;
        end
      end
      hvn_pkg::ST_CELL_DIV: begin
        if (smp_r != 2'd0) begin
          req.start = 1'b1; req.is_div = 1'b1;
          req.a = 80'({vmag, 30'd0}) + 80'(s_r >> 1); req.d = s_r;
          smp_nxt = 2'd0;
        end
        if (rsp.done) begin
          acc_nxt[cmp_r] = acc_r[cmp_r] + (vk[16] ? -24'(qv) : 24'(qv));
          smp_nxt = 2'd1;
          if (cmp_r == 2'd2) begin
            if (cell_r == 2'd3) begin
              st_nxt = hvn_pkg::ST_SUM_SQ; cmp_nxt = 2'd0; sq_nxt = '0;
            end else begin
              st_nxt = hvn_pkg::ST_FETCH; smp_nxt = 2'd0;
            end
            cell_nxt = cell_r + 2'd1;
          end else cmp_nxt = cmp_r + 2'd1;
        end
      end
      hvn_pkg::ST_SUM_SQ: begin
        sq_nxt = sq_r + 48'(amag) * 48'(amag);
        if (cmp_r == 2'd2) st_nxt = hvn_pkg::ST_SUM_SQRT;
        else cmp_nxt = cmp_r + 2'd1;
      end
      hvn_pkg::ST_SUM_SQRT: begin
        if (sq_r == '0) begin
          o_nxt[0] = '0; o_nxt[1] = 16'sd16384; o_nxt[2] = '0;
          st_nxt = hvn_pkg::ST_OUT;
        end else begin
          req.start = (cmp_r == 2'd2); req.a = {sq_r, 16'd0, 16'd0};
          cmp_nxt = 2'd3;
          if (rsp.done) begin
            s_nxt = 48'(qv[79:8]); cmp_nxt = 2'd0; smp_nxt = 2'd1;
            st_nxt = hvn_pkg::ST_SUM_DIV; req.start = 1'b0;
          end
        end
      end
      hvn_pkg::ST_SUM_DIV: begin
        if (smp_r != 2'd0) begin
          req.start = 1'b1; req.is_div = 1'b1;
          req.a = 80'({amag, 22'd0}) + 80'(s_r >> 1); req.d = s_r;
          smp_nxt = 2'd0;
        end
        if (rsp.done) begin
          qsat = (qv > 80'd16384) ? 17'd16384 : qv[16:0];
          o_nxt[cmp_r] = ak[23] ? -16'(qsat) : 16'(qsat);
          smp_nxt = 2'd1;
          if (cmp_r == 2'd2) st_nxt = hvn_pkg::ST_OUT;
          else cmp_nxt = cmp_r + 2'd1;
        end
      end
      hvn_pkg::ST_OUT: begin
        // hand over once the output register can take the word
        if (out_free) begin
          done = 1'b1; st_nxt = hvn_pkg::ST_IDLE;
        end
      end
      default: st_nxt = hvn_pkg::ST_IDLE;
    endcase
  end

  // state registers; cell vector from the three samples, divisor as y
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hvn_pkg::ST_IDLE;
      cell_r <= '0; smp_r <= '0; cmp_r <= '0;
    end else begin
      st_r <= st_nxt; cell_r <= cell_nxt; smp_r <= smp_nxt; cmp_r <= cmp_nxt;
    end
    row_r <= row_nxt; col_r <= col_nxt;
    h00_r <= h00_nxt; h10_r <= h10_nxt; h11_r <= h11_nxt;
    acc_r <= acc_nxt; sq_r <= sq_nxt; s_r <= s_nxt; o_r <= o_nxt;
    if (st_r == hvn_pkg::ST_WAIT && smp_r == 2'd3) begin
      v_r[0] <= 17'(($signed({9'd0, h10_r}) - $signed({9'd0, rd_data})) * 256);
      v_r[1] <= $signed({1'b0, dv});
      v_r[2] <= 17'(($signed({9'd0, h10_r}) - $signed({9'd0, h00_r})) * 256);
    end
  end

  assign nx = o_r[0];
  assign ny = o_r[1];
  assign nz = o_r[2];
endmodule

// ===== hw/rtl/heightmap_vertex_normals_unit.sv =====
// Heightmap vertex normal unit.
// Channels: in (load or query word), out (normal word), cfg (register write).
// Load words write the height store (65536 x 8 RAM); the next word can be
// taken in the following cycle.
// A query reads up to twelve samples, one per cycle from the single RAM port,
// and runs one iterative root/divide unit one bit per cycle. Each adjacent
// cell takes a fetch, three reads, three squares, a root and three divides,
// an absent cell only a skip step, and the final sum three squares, a root,
// three divides and the handover.
// One query is in flight at a time; the input is held off while it runs.
// The result sits in an output register and the next word may be accepted
// while it waits. A stalled receiver blocks the input only once a further
// query has finished and must wait for the register.
// Reset restores registers to 256/256/256 and leaves the store unwritten;
// no clearing pass.
// Depends on hvn_pkg, hvn_if, hvn_ram, hvn_ctrl.
module heightmap_vertex_normals_unit (
  input  logic      clk,
  input  logic      rst_n,
  hvn_in_if.sink    in_ch,
  hvn_out_if.source out_ch,
  hvn_cfg_if.sink   cfg_ch
);
  logic [8:0]  gw_r, gh_r;
  logic [15:0] dv_r;
  logic [8:0]  w, h;
  logic [15:0] dv;
  logic        in_fire, in_range, we, qstart, busy, done, out_free;
  logic [15:0] qaddr;
  logic [7:0]  rdata;
  logic        ov_r;
  logic signed [15:0] nx, ny, nz, ox_r, oy_r, oz_r;

  // clamp registers to the store size, a zero divisor to 1
  assign w  = (gw_r > 9'(hvn_pkg::MAX_COLS)) ? 9'(hvn_pkg::MAX_COLS) : gw_r;
  assign h  = (gh_r > 9'(hvn_pkg::MAX_ROWS)) ? 9'(hvn_pkg::MAX_ROWS) : gh_r;
  assign dv = (dv_r == '0) ? 16'd1 : dv_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_range = ({1'b0, in_ch.row} < h) && ({1'b0, in_ch.col} < w);
  assign we     = in_fire && in_range && (in_ch.kind == hvn_pkg::KIND_LOAD);
  assign qstart = in_fire && in_range && (in_ch.kind == hvn_pkg::KIND_QUERY);
  assign out_free = !ov_r || out_ch.ready;

  hvn_ram #(.Width(8), .Depth(65536)) u_ram (
    .clk(clk), .we(we),
    .addr(we ? {in_ch.row, in_ch.col} : qaddr),
    .wdata(in_ch.height), .rdata(rdata)
  );

  hvn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(qstart), .row(in_ch.row), .col(in_ch.col),
    .w(w), .h(h), .dv(dv), .out_free(out_free), .rd_addr(qaddr), .rd_data(rdata),
    .busy(busy), .done(done), .nx(nx), .ny(ny), .nz(nz)
  );

  // config registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 9'd256; gh_r <= 9'd256; dv_r <= 16'd256; ov_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          hvn_pkg::CFG_GRID_WIDTH:  gw_r <= cfg_ch.data[8:0];
          hvn_pkg::CFG_GRID_HEIGHT: gh_r <= cfg_ch.data[8:0];
          hvn_pkg::CFG_HEIGHT_DIV:  dv_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (done) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    if (done) begin
      ox_r <= nx; oy_r <= ny; oz_r <= nz;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.normal_x = ox_r;
  assign out_ch.normal_y = oy_r;
  assign out_ch.normal_z = oz_r;
endmodule

// ===== verif/hvn_checker.sv =====
`timescale 1ns / 1ps
// Checker for the heightmap vertex normal unit: watches the in, out and cfg
// channels, keeps its own height store and registers, predicts each normal.
// Depends on hvn_pkg and the channel interfaces in hvn_if.
module hvn_checker (
  input  logic clk,
  input  logic rst_n,
  hvn_in_if    in_mon,
  hvn_out_if   out_mon,
  hvn_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } normal_t;

  logic [7:0]  heights [65536];
  logic [8:0]  cols_reg;
  logic [8:0]  rows_reg;
  logic [15:0] div_reg;
  normal_t     normals_due[$];

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // sign(v) * round(|v| * 2^sh / d), halves away from zero
  function automatic longint shift_div(longint v, int sh, longint unsigned d);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << sh) + d / 2) / d;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  // add unit normal (Q.20) of cell (r,c) into acc
  function automatic void add_face(int r, int c, longint unsigned d, ref longint acc[3]);
    longint h00, h10, h11, l2;
    longint v[3];
    longint unsigned s;
    h00 = heights[r * 256 + c];
    h10 = heights[(r + 1) * 256 + c];
    h11 = heights[(r + 1) * 256 + c + 1];
    v[0] = 256 * (h10 - h11);
    v[1] = longint'(d);
    v[2] = 256 * (h10 - h00);
    l2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    s = int_sqrt(longint'(l2) << 20);
    for (int k = 0; k < 3; k++) acc[k] += shift_div(v[k], 30, s);
  endfunction

  function automatic normal_t vertex_normal(int r, int c, int w, int h);
    longint acc[3];
    longint unsigned d, s2, t;
    longint q;
    normal_t n;
    acc = '{0, 0, 0};
    d = (div_reg == 0) ? 1 : div_reg;
    if (r >= 1 && c >= 1)         add_face(r - 1, c - 1, d, acc);
    if (r >= 1 && c + 1 < w)      add_face(r - 1, c, d, acc);
    if (r + 1 < h && c >= 1)      add_face(r, c - 1, d, acc);
    if (r + 1 < h && c + 1 < w)   add_face(r, c, d, acc);
    s2 = acc[0] * acc[0] + acc[1] * acc[1] + acc[2] * acc[2];
    if (s2 == 0) begin
      n.x = 0; n.y = 16'sd16384; n.z = 0;
      return n;
    end
    t = int_sqrt(s2 << 16);
    for (int k = 0; k < 3; k++) begin
      q = shift_div(acc[k], 22, t);
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      case (k)
        0: n.x = q[15:0];
        1: n.y = q[15:0];
        default: n.z = q[15:0];
      endcase
    end
    return n;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] normal mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int w, h, r, c;
    normal_t want;
    if (!rst_n) begin
      cols_reg <= 9'd256;
      rows_reg <= 9'd256;
      div_reg  <= 16'd256;
      fail_count = 0;
      normals_due.delete();
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          hvn_pkg::CFG_GRID_WIDTH:  cols_reg <= cfg_mon.data[8:0];
          hvn_pkg::CFG_GRID_HEIGHT: rows_reg <= cfg_mon.data[8:0];
          hvn_pkg::CFG_HEIGHT_DIV:  div_reg  <= cfg_mon.data;
          default: ;
        endcase
      end
      // results against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (normals_due.size() == 0) begin
          $display("[%0t] normal word with nothing expected", $time);
          fail_count++;
        end else begin
          want = normals_due.pop_front();
          if (out_mon.normal_x !== want.x) report("x", out_mon.normal_x, want.x);
          if (out_mon.normal_y !== want.y) report("y", out_mon.normal_y, want.y);
          if (out_mon.normal_z !== want.z) report("z", out_mon.normal_z, want.z);
        end
      end
      // input words: loads update the store, queries predict
      if (in_mon.valid && in_mon.ready) begin
        w = (cols_reg > 256) ? 256 : cols_reg;
        h = (rows_reg > 256) ? 256 : rows_reg;
        r = in_mon.row;
        c = in_mon.col;
        if (r < h && c < w) begin
          if (in_mon.kind == hvn_pkg::KIND_LOAD) heights[r * 256 + c] = in_mon.height;
          else normals_due.push_back(vertex_normal(r, c, w, h));
        end
      end
    end
    pending <= normals_due.size();
  end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the heightmap vertex normal unit testbench: clock, reset, stimulus
// and verdict. Depends on hvn_pkg, hvn_if, the unit and hvn_checker.
module testbench;
  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   written [65536];
  int   cur_w, cur_h;
  bit   send_burst, recv_burst;

  hvn_in_if  in_ch();
  hvn_out_if out_ch();
  hvn_cfg_if cfg_ch();

  heightmap_vertex_normals_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  hvn_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // result side: random stall before each word, bursts with none
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_word(logic kind, int r, int c, int hv);
    int gap;
    if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.row    <= r[7:0];
    in_ch.col    <= c[7:0];
    in_ch.height <= hv[7:0];
    do @(posedge clk); while (!in_ch.ready);
    if (kind == hvn_pkg::KIND_LOAD && r < cur_h && c < cur_w) written[r * 256 + c] = 1'b1;
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[15:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every normal is back, then let a query in flight drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (1500) @(posedge clk);
  endtask

  function automatic int steep_height();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic run_phase(int w, int h, int d, int n);
    int r, c, p;
    drain();
    write_reg(hvn_pkg::CFG_GRID_WIDTH, w);
    write_reg(hvn_pkg::CFG_GRID_HEIGHT, h);
    write_reg(hvn_pkg::CFG_HEIGHT_DIV, d);
    cur_w = (w > 256) ? 256 : w;
    cur_h = (h > 256) ? 256 : h;
    // fill every sample of the grid that is still unwritten
    for (int rr = 0; rr < cur_h; rr++)
      for (int cc = 0; cc < cur_w; cc++)
        if (!written[rr * 256 + cc]) send_word(hvn_pkg::KIND_LOAD, rr, cc, steep_height());
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 8 || cur_w == 0 || cur_h == 0) begin
        r = $urandom_range(0, 255);
        c = $urandom_range(0, 255);
        if (cur_w < 256 && cur_w > 0) c = $urandom_range(cur_w, 255);
        else if (cur_h < 256 && cur_h > 0) r = $urandom_range(cur_h, 255);
        if (r < cur_h && c < cur_w) send_word(hvn_pkg::KIND_LOAD, r, c, steep_height());
        else send_word(logic'($urandom_range(0, 1)), r, c, $urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, cur_h - 1);
        c = $urandom_range(0, cur_w - 1);
        if (p < 45) send_word(hvn_pkg::KIND_QUERY, r, c, $urandom_range(0, 255));
        else send_word(hvn_pkg::KIND_LOAD, r, c, steep_height());
      end
    end
  endtask

  // load a 3x3 patch around (r,c), clipped, then query the vertex
  task automatic patch_query(int r, int c);
    for (int rr = r - 1; rr <= r + 1; rr++)
      for (int cc = c - 1; cc <= c + 1; cc++)
        if (rr >= 0 && cc >= 0 && rr < 256 && cc < 256)
          send_word(hvn_pkg::KIND_LOAD, rr, cc, ((rr + cc) % 2) ? 255 : 0);
    send_word(hvn_pkg::KIND_QUERY, r, c, 0);
  endtask

  initial begin
    send_burst = 1'b0;
    cur_w = 256;
    cur_h = 256;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = hvn_pkg::KIND_LOAD;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.height = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hvn_pkg::CFG_GRID_WIDTH;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners and a middle vertex under reset registers
    patch_query(0, 0);
    patch_query(255, 255);
    patch_query(128, 128);

    // unused register index must be ignored
    drain();
    write_reg(2'd3, 16'hffff);

    run_phase(2, 2, 1, 40);
    run_phase(5, 7, 0, 50);
    run_phase(300, 2, 65535, 50);
    run_phase(2, 511, 256, 50);
    run_phase(1, 6, 100, 30);
    run_phase(0, 4, 256, 20);
    run_phase(13, 9, 40000, 60);
    run_phase(16, 16, 300, 60);
    run_phase(3, 3, 65535, 40);
    for (int i = 0; i < 4; i++)
      run_phase($urandom_range(2, 20), $urandom_range(2, 20), $urandom_range(1, 65535), 60);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (1500) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // hard limit on the run
  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
